### hw/rtl/bcr_pkg.sv
// ----------------------------------------------------------------------------
// bcr_pkg
// Shared types and constants for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package bcr_pkg;

    localparam int COORD_BITS = 12;
    localparam int DEC_BITS   = 16;
    localparam int PIX_BITS   = 13;

    // Input field widths and their places in the input tdata word.
    localparam int CX_BITS    = 12;
    localparam int CY_BITS    = 12;
    localparam int RAD_BITS   = 10;
    localparam int CX_LSB     = 0;
    localparam int CY_LSB     = CX_LSB + CX_BITS;
    localparam int RAD_LSB    = CY_LSB + CY_BITS;
    localparam int IN_BITS    = RAD_LSB + RAD_BITS;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam int OUT_BITS    = 2 * PIX_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Wide enough for any sign extension done before a wrap.
    localparam int WIDE_W = COORD_BITS + DEC_BITS + RAD_BITS;

    // Width of the center plus offset sums in the plotter.
    localparam int SUM_W = (COORD_BITS + 1 > PIX_BITS) ? COORD_BITS + 1 : PIX_BITS;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    // One set of eight points waiting to be plotted.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic                         done;
    } job_t;

endpackage

### hw/rtl/bcr_front.sv
// ----------------------------------------------------------------------------
// bcr_front
// Takes start and step words, runs the decision update and pushes at most one job per word.
// ----------------------------------------------------------------------------
module bcr_front
    import bcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  opcode_t               opcode,
    input  logic signed [CX_BITS-1:0]  center_x,
    input  logic signed [CY_BITS-1:0]  center_y,
    input  logic [RAD_BITS-1:0]   radius,
    output logic                  push,
    output job_t                  push_job,
    input  logic                  q_ready
);

    logic signed [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic signed [COORD_BITS-1:0] pos_y_reg, pos_y_next;
    logic signed [COORD_BITS-1:0] held_cx_reg, held_cx_next;
    logic signed [COORD_BITS-1:0] held_cy_reg, held_cy_next;
    logic signed [DEC_BITS-1:0]   decision_reg, decision_next;
    logic                         active_reg, active_next;

    logic                         accept;
    logic signed [COORD_BITS-1:0] x_inc, y_dec;
    logic signed [COORD_BITS:0]   diff;
    logic signed [WIDE_W-1:0]     diff_ext, x_ext, cx_ext, cy_ext;
    logic [WIDE_W-1:0]            r_ext;
    logic [DEC_BITS-1:0]          diff_d, x_d;
    logic                         dec_pos, step_ok;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        x_inc    = COORD_BITS'(pos_x_reg + COORD_BITS'(1));
        y_dec    = COORD_BITS'(pos_y_reg - COORD_BITS'(1));
        diff     = (COORD_BITS+1)'(x_inc) - (COORD_BITS+1)'(y_dec);
        diff_ext = WIDE_W'(diff);
        x_ext    = WIDE_W'(x_inc);
        diff_d   = diff_ext[DEC_BITS-1:0];
        x_d      = x_ext[DEC_BITS-1:0];
        cx_ext   = WIDE_W'(center_x);
        cy_ext   = WIDE_W'(center_y);
        r_ext    = WIDE_W'(radius);
        dec_pos  = !decision_reg[DEC_BITS-1] && (decision_reg != '0);
        step_ok  = active_reg && !(pos_y_reg < pos_x_reg);

        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        held_cx_next  = held_cx_reg;
        held_cy_next  = held_cy_reg;
        decision_next = decision_reg;
        active_next   = active_reg;
        push          = 1'b0;

        if (accept)
        begin
            unique case (opcode)
                OP_START:
                begin
                    held_cx_next  = cx_ext[COORD_BITS-1:0];
                    held_cy_next  = cy_ext[COORD_BITS-1:0];
                    pos_x_next    = '0;
                    pos_y_next    = r_ext[COORD_BITS-1:0];
                    decision_next = DEC_BITS'(3) - {r_ext[DEC_BITS-2:0], 1'b0};
                    active_next   = 1'b1;
                    push          = 1'b1;
                end
                OP_STEP:
                begin
                    if (step_ok)
                    begin
                        pos_x_next = x_inc;
                        push       = 1'b1;
                        if (dec_pos)
                        begin
                            pos_y_next    = y_dec;
                            decision_next = decision_reg
                                          + {diff_d[DEC_BITS-3:0], 2'b00}
                                          + DEC_BITS'(10);
                        end
                        else
                        begin
                            decision_next = decision_reg
                                          + {x_d[DEC_BITS-3:0], 2'b00}
                                          + DEC_BITS'(6);
                        end
                        if (pos_y_next < pos_x_next)
                        begin
                            active_next = 1'b0;
                        end
                    end
                    else
                    begin
                        active_next = 1'b0;
                    end
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end

        push_job.center_x = held_cx_next;
        push_job.center_y = held_cy_next;
        push_job.pos_x    = pos_x_next;
        push_job.pos_y    = pos_y_next;
        // A start always leaves y >= x, so done can only rise on a step.
        push_job.done     = pos_y_next < pos_x_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            held_cx_reg  <= '0;
            held_cy_reg  <= '0;
            decision_reg <= '0;
            active_reg   <= 1'b0;
        end
        else
        begin
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            held_cx_reg  <= held_cx_next;
            held_cy_reg  <= held_cy_next;
            decision_reg <= decision_next;
            active_reg   <= active_next;
        end
    end

endmodule

### hw/rtl/bcr_queue.sv
// ----------------------------------------------------------------------------
// bcr_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module bcr_queue
    import bcr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic ready,
    input  logic pop,
    output logic valid,
    output job_t pop_job
);

    job_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign ready   = (count_reg != 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign pop_job = mem[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/bcr_back.sv
// ----------------------------------------------------------------------------
// bcr_back
// Walks the eight symmetric points of a job into a registered output word.
// ----------------------------------------------------------------------------
module bcr_back
    import bcr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  job_t                       q_job,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [PIX_BITS-1:0] pixel_x,
    output logic signed [PIX_BITS-1:0] pixel_y,
    output logic                       last_of_step,
    output logic                       circle_done
);

    job_t                       job_reg, job_next;
    logic                       job_valid_reg, job_valid_next;
    logic [2:0]                 idx_reg, idx_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [PIX_BITS-1:0] px_reg, px_next;
    logic signed [PIX_BITS-1:0] py_reg, py_next;
    logic                       last_reg, last_next;
    logic                       done_reg, done_next;

    logic                       out_load, final_pt;
    logic signed [COORD_BITS-1:0] a, b;
    logic signed [SUM_W-1:0]    cxe, cye, ae, be, sx, sy;

    assign out_load = job_valid_reg && (!out_valid_reg || out_ready);
    assign final_pt = (idx_reg == 3'd7);
    assign pop      = q_valid && (!job_valid_reg || (out_load && final_pt));

    always_comb
    begin
        // Points 0..3 use (x, y), points 4..7 the swapped pair (y, x).
        a   = idx_reg[2] ? job_reg.pos_y : job_reg.pos_x;
        b   = idx_reg[2] ? job_reg.pos_x : job_reg.pos_y;
        cxe = SUM_W'(job_reg.center_x);
        cye = SUM_W'(job_reg.center_y);
        ae  = SUM_W'(a);
        be  = SUM_W'(b);
        sx  = idx_reg[0] ? cxe - ae : cxe + ae;
        sy  = idx_reg[1] ? cye - be : cye + be;

        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        last_next      = last_reg;
        done_next      = done_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            px_next        = sx[PIX_BITS-1:0];
            py_next        = sy[PIX_BITS-1:0];
            last_next      = final_pt;
            done_next      = final_pt && job_reg.done;
            idx_next       = idx_reg + 3'd1;
            if (final_pt)
            begin
                job_valid_next = 1'b0;
            end
        end

        if (pop)
        begin
            job_next       = q_job;
            job_valid_next = 1'b1;
            idx_next       = 3'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        px_reg  <= px_next;
        py_reg  <= py_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            done_reg      <= done_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = px_reg;
    assign pixel_y      = py_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

endmodule

### hw/rtl/bresenham_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// bresenham_circle_rasterizer
// Midpoint circle rasterizer with eight-way symmetric output.
// ----------------------------------------------------------------------------
// A start word (tuser 0) loads center and radius and a step word (tuser 1)
// advances the octant walk by one column; each of them yields eight output
// words, one per cycle while m_tready is high, the eighth marked by tlast
// and, when the circle has just closed, by tuser. A step while no circle is
// running yields nothing. The front takes words only as fast as their points
// drain; it runs the decision update in the cycle it takes a word, and a
// two-job queue lets it take up to two words ahead of the plotter. A point
// leaves through the queue, the job register and the output register.
// ----------------------------------------------------------------------------
module bresenham_circle_rasterizer
    import bcr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // center_x, center_y, radius, zero fill
    input  logic                   s_tuser,   // opcode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // pixel_x, pixel_y, zero fill
    output logic                   m_tuser,   // circle_done
    output logic                   m_tlast    // last_of_step
);

    logic                       push, q_ready, q_valid, pop;
    job_t                       push_job, pop_job;
    logic signed [PIX_BITS-1:0] pixel_x, pixel_y;
    opcode_t                    opcode;

    assign opcode = opcode_t'(s_tuser);

    bcr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .opcode   (opcode),
        .center_x (s_tdata[CX_LSB +: CX_BITS]),
        .center_y (s_tdata[CY_LSB +: CY_BITS]),
        .radius   (s_tdata[RAD_LSB +: RAD_BITS]),
        .push     (push),
        .push_job (push_job),
        .q_ready  (q_ready)
    );

    bcr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .ready    (q_ready),
        .pop      (pop),
        .valid    (q_valid),
        .pop_job  (pop_job)
    );

    bcr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_job        (pop_job),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .last_of_step (m_tlast),
        .circle_done  (m_tuser)
    );

    assign m_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, pixel_y, pixel_x};

endmodule
